### rtl/pcd_pkg.sv
// Package for the proportional chunk dispatcher.
// Holds field widths, register indexes, result codes, FSM states and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package pcd_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DEV_FIELD_W = 4;
  localparam int unsigned DEV_SPACE   = 2 ** DEV_FIELD_W;
  localparam int unsigned IN_TDATA_W  = 40;   // device + done_size, padded to bytes
  localparam int unsigned OUT_TDATA_W = 72;   // device + offset + size, padded to bytes
  localparam int unsigned ADDR_W      = 3;

  // Divider: dividend is 5 * count, which needs three more bits than a count.
  localparam int unsigned DIV_W     = DATA_W + 3;
  localparam int unsigned STEP_W    = 6;
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(DIV_W);

  localparam logic [DATA_W-1:0] BASE_CHUNK_RST = 32'd128;

  // Register index, taken from paddr[2]
  localparam logic REG_TOTAL_SIZE = 1'b0;
  localparam logic REG_BASE_CHUNK = 1'b1;

  // Input item kinds
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_REPORT  = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANT   = 2'd0,
    ST_NOWORK  = 2'd1,
    ST_REQUEUE = 2'd2,
    ST_DONE    = 2'd3
  } pcd_status_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_DIV    = 6'b000100,
    S_MUL    = 6'b001000,
    S_GRANT  = 6'b010000,
    S_FINISH = 6'b100000
  } pcd_state_e;

  typedef struct packed {
    logic load;      // capture the accepted item
    logic decide;    // resolve simple items or start the divider
    logic div_step;  // one quotient bit
    logic mul;       // saturate multiplier, take product
    logic grant;     // clip and commit a granted chunk
    logic push;      // move staged result to the output register
  } pcd_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } pcd_sts_t;

endpackage

### rtl/proportional_chunk_dispatcher.sv
// Channel     Direction  Content
// s_t*        in         item: tuser action, tdata device and done_size
// m_t*        out        item: tuser status, tdata device, offset and size
// APB         in/out     total_size at 0x0, base_chunk at 0x4
//
// A completion report or a request that finds no work passes through the decide and
// finish states to the output register; the next item is taken once the result is
// pushed. A granted chunk also passes through the bit-serial divider (5 * count /
// total count), the multiply and the grant states. One item is in work at a time.
// A finished item waits in a staging register while the output register is
// stalled. Reset is asynchronous: all counters clear, every device is enabled,
// base_chunk returns to 128. Top level; uses pcd_pkg, pcd_ctrl and pcd_dp.
`timescale 1ns / 1ps

module proportional_chunk_dispatcher
  import pcd_pkg::*;
#(
  parameter int unsigned DEVICES = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,   // device[3:0], done_size[35:4], zeros
  input  logic                   s_tuser_i,   // action[0]
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,   // chunk_device[3:0], chunk_offset[35:4],
                                              // chunk_size[67:36], zeros
  output logic [1:0]             m_tuser_o,   // status[1:0]
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  pcd_cmd_t               cmd;
  pcd_sts_t               sts;
  logic                   cfg_we;
  logic [DATA_W-1:0]      total_size, base_chunk;
  logic [DEVICES-1:0]     dev_en;
  pcd_status_e            out_status;
  logic [DEV_FIELD_W-1:0] out_device;
  logic [DATA_W-1:0]      out_offset, out_size;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_BASE_CHUNK) ? base_chunk : total_size;

  pcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcd_dp #(
    .DEVICES (DEVICES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_action_i    (s_tuser_i),
    .in_device_i    (s_tdata_i[DEV_FIELD_W-1:0]),
    .in_done_i      (s_tdata_i[DEV_FIELD_W +: DATA_W]),
    .cfg_we_total_i (cfg_we && (paddr[2] == REG_TOTAL_SIZE)),
    .cfg_we_base_i  (cfg_we && (paddr[2] == REG_BASE_CHUNK)),
    .cfg_wdata_i    (pwdata),
    .total_size_o   (total_size),
    .base_chunk_o   (base_chunk),
    .dev_en_o       (dev_en),
    .out_status_o   (out_status),
    .out_device_o   (out_device),
    .out_offset_o   (out_offset),
    .out_size_o     (out_size)
  );

  assign m_tuser_o = out_status;
  assign m_tdata_o = {(OUT_TDATA_W - DEV_FIELD_W - 2 * DATA_W)'(0),
                      out_size, out_offset, out_device};

`ifndef SYNTHESIS
  logic [DEV_SPACE-1:0] en_ext;
  logic                 out_dev_ok;

  assign en_ext     = DEV_SPACE'(dev_en);
  assign out_dev_ok = ({1'b0, out_device} < (DEV_FIELD_W + 1)'(DEVICES));

  // an unknown device gets an empty no-work answer
  a_bad_dev_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !out_dev_ok) |->
      (out_status == ST_NOWORK && out_offset == '0 && out_size == '0))
    else $error("out-of-range device produced a nonempty result");

  // a finished or starved device stays disabled
  a_dev_disabled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && out_dev_ok && (out_status == ST_DONE || out_status == ST_NOWORK))
      |-> !en_ext[out_device])
    else $error("device still enabled after done or no-work result");

  // a granted chunk lies inside the work range
  a_grant_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && out_status == ST_GRANT) |->
      ((DATA_W + 1)'(out_offset) + (DATA_W + 1)'(out_size) <= (DATA_W + 1)'(total_size)))
    else $error("granted chunk runs past total_size");
`endif

endmodule

### rtl/pcd_ctrl.sv
// Controller FSM of the proportional chunk dispatcher.
// Sequences capture, decision, divide, multiply, commit and output; uses pcd_pkg.
`timescale 1ns / 1ps

module pcd_ctrl
  import pcd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  output logic     m_tvalid_o,
  input  logic     m_tready_i,
  input  pcd_sts_t sts_i,
  output pcd_cmd_t cmd_o
);

  pcd_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.need_div ? S_DIV : S_FINISH;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_GRANT;
      end
      S_GRANT: begin
        cmd_o.grant = 1'b1;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        // hold the staged result until the output register frees up
        if (!out_valid_q || m_tready_i) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;

endmodule

### rtl/pcd_dp.sv
// Datapath of the proportional chunk dispatcher: work counters, per-device
// chunk counts, bit-serial divider, multiplier and result registers; uses pcd_pkg.
`timescale 1ns / 1ps

module pcd_dp
  import pcd_pkg::*;
#(
  parameter int unsigned DEVICES = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pcd_cmd_t               cmd_i,
  output pcd_sts_t               sts_o,
  input  logic                   in_action_i,
  input  logic [DEV_FIELD_W-1:0] in_device_i,
  input  logic [DATA_W-1:0]      in_done_i,
  input  logic                   cfg_we_total_i,
  input  logic                   cfg_we_base_i,
  input  logic [DATA_W-1:0]      cfg_wdata_i,
  output logic [DATA_W-1:0]      total_size_o,
  output logic [DATA_W-1:0]      base_chunk_o,
  output logic [DEVICES-1:0]     dev_en_o,
  output pcd_status_e            out_status_o,
  output logic [DEV_FIELD_W-1:0] out_device_o,
  output logic [DATA_W-1:0]      out_offset_o,
  output logic [DATA_W-1:0]      out_size_o
);

  localparam int unsigned IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  // captured item
  logic                   action_q;
  logic [DEV_FIELD_W-1:0] dev_q;
  logic [DATA_W-1:0]      done_q;

  // work state
  logic [DATA_W-1:0] total_q, base_q, off_q, rtg_q, rtc_q, tot_cnt_q;
  logic [DATA_W-1:0] cnt_q [DEVICES];
  logic [DEVICES-1:0] en_q;

  // divider and multiplier
  logic [DATA_W-1:0] divisor_q, rem_q;
  logic [DIV_W-1:0]  dq_q;
  logic [STEP_W-1:0] step_q;
  logic [63:0]       prod_q;

  // staged and output results
  pcd_status_e            res_status_q, out_status_q;
  logic [DEV_FIELD_W-1:0] res_dev_q, out_dev_q;
  logic [DATA_W-1:0]      res_off_q, res_size_q, out_off_q, out_size_q;

  logic              dev_ok;
  logic [IDX_W-1:0]  idx;
  logic [DATA_W-1:0] cnt_sel;
  logic [DATA_W:0]   rem_sh;
  logic              rem_ge;
  logic [DIV_W:0]    q_inc;
  logic [DATA_W-1:0] mult;
  logic [63:0]       prod_w;
  logic [DATA_W-1:0] grant_size;

  assign dev_ok  = ({1'b0, dev_q} < (DEV_FIELD_W + 1)'(DEVICES));
  assign idx     = dev_q[IDX_W-1:0];
  assign cnt_sel = cnt_q[idx];

  assign sts_o.need_div = dev_ok && (action_q == ACT_REQUEST) && (rtg_q != '0);
  assign sts_o.div_last = (step_q == STEP_W'(1));

  // restoring divide step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_q, dq_q[DIV_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, divisor_q});

  // multiplier is 1 + quotient, saturated to 32 bits
  assign q_inc  = {1'b0, dq_q} + (DIV_W + 1)'(1);
  assign mult   = (|q_inc[DIV_W:DATA_W]) ? '1 : q_inc[DATA_W-1:0];
  assign prod_w = 64'(base_q) * 64'(mult);

  assign grant_size = (prod_q > 64'(rtg_q)) ? rtg_q : prod_q[DATA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= in_action_i;
      dev_q    <= in_device_i;
      done_q   <= in_done_i;
    end
    if (cmd_i.decide && sts_o.need_div) begin
      divisor_q <= (tot_cnt_q == '0) ? DATA_W'(1) : tot_cnt_q;
      rem_q     <= '0;
      dq_q      <= DIV_W'(cnt_sel) + (DIV_W'(cnt_sel) << 2);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sh[DATA_W-1:0] - divisor_q : rem_sh[DATA_W-1:0];
      dq_q  <= {dq_q[DIV_W-2:0], rem_ge};
    end
    if (cmd_i.mul) begin
      prod_q <= prod_w;
    end
    if (cmd_i.push) begin
      out_status_q <= res_status_q;
      out_dev_q    <= res_dev_q;
      out_off_q    <= res_off_q;
      out_size_q   <= res_size_q;
    end
    if (cmd_i.decide) begin
      res_dev_q  <= dev_q;
      res_off_q  <= '0;
      res_size_q <= '0;
      if (!dev_ok || action_q == ACT_REQUEST) begin
        res_status_q <= ST_NOWORK;
      end else if (done_q >= rtc_q) begin
        res_status_q <= ST_DONE;
      end else begin
        res_status_q <= ST_REQUEUE;
      end
    end else if (cmd_i.grant) begin
      res_status_q <= ST_GRANT;
      res_off_q    <= off_q;
      res_size_q   <= grant_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      base_q    <= BASE_CHUNK_RST;
      off_q     <= '0;
      rtg_q     <= '0;
      rtc_q     <= '0;
      tot_cnt_q <= '0;
      en_q      <= '1;
      step_q    <= '0;
      for (int i = 0; i < DEVICES; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_total_i) begin
        total_q <= cfg_wdata_i;
        off_q   <= '0;
        rtg_q   <= cfg_wdata_i;
        rtc_q   <= cfg_wdata_i;
      end
      if (cfg_we_base_i) begin
        base_q <= cfg_wdata_i;
      end
      if (cmd_i.decide) begin
        if (sts_o.need_div) begin
          step_q <= DIV_STEPS;
        end else if (dev_ok) begin
          if (action_q == ACT_REQUEST) begin
            en_q[idx] <= 1'b0;
          end else if (done_q >= rtc_q) begin
            rtc_q     <= '0;
            en_q[idx] <= 1'b0;
          end else begin
            rtc_q <= rtc_q - done_q;
          end
        end
      end
      if (cmd_i.div_step) begin
        step_q <= step_q - STEP_W'(1);
      end
      if (cmd_i.grant) begin
        rtg_q      <= rtg_q - grant_size;
        off_q      <= off_q + grant_size;
        cnt_q[idx] <= cnt_q[idx] + DATA_W'(1);
        tot_cnt_q  <= tot_cnt_q + DATA_W'(1);
      end
    end
  end

  assign total_size_o = total_q;
  assign base_chunk_o = base_q;
  assign dev_en_o     = en_q;
  assign out_status_o = out_status_q;
  assign out_device_o = out_dev_q;
  assign out_offset_o = out_off_q;
  assign out_size_o   = out_size_q;

endmodule
